// ===== src/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg
// shared codes, defaults and controller/datapath link types for the
// restricted circular deque
// ----------------------------------------------------------------------------
package rcd_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int WORD_W        = 32;
    localparam int KIND_W        = 3;
    localparam int STATUS_W      = 3;

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_INS_REAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REM_FRONT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REM_REAR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DISPLAY   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOWED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY_SHOW  = 3'd4;

    // restriction modes
    localparam logic MODE_INPUT_RESTRICTED  = 1'b0;
    localparam logic MODE_OUTPUT_RESTRICTED = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic accept;   // input transaction taken this cycle
        logic advance;  // display moves on to the next word
    } rcd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;     // result held in the output register is the final one
    } rcd_sts_t;

endpackage

// ===== src/rcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcd_ctrl
// handshake controller: takes one input transaction, then holds the
// output channel until the final result has been taken
// ----------------------------------------------------------------------------
module rcd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  rcd_pkg::rcd_sts_t sts,
    output rcd_pkg::rcd_cmd_t cmd
);
    import rcd_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.accept     = 1'b0;
        cmd.advance    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept     = 1'b1;
                    state_next     = S_RESP;
                    out_valid_next = 1'b1;
                end
            end
            S_RESP:
            begin
                if (!out_stall)
                begin
                    if (sts.last)
                    begin
                        state_next     = S_IDLE;
                        out_valid_next = 1'b0;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/rcd_datapath.sv =====
// ----------------------------------------------------------------------------
// rcd_datapath
// slot memory, wrapping front/rear pointers, empty mark, mode register
// and the output register
// ----------------------------------------------------------------------------
module rcd_datapath
#(
    parameter int DEPTH = rcd_pkg::DEPTH_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic [rcd_pkg::KIND_W-1:0]   kind,
    input  logic signed [rcd_pkg::WORD_W-1:0] push_value,
    input  rcd_pkg::rcd_cmd_t            cmd,
    output rcd_pkg::rcd_sts_t            sts,
    output logic [rcd_pkg::STATUS_W-1:0] status,
    output logic                         value_valid,
    output logic signed [rcd_pkg::WORD_W-1:0] out_value,
    output logic                         last
);
    import rcd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_MAX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_MAX : p - 1'b1;
    endfunction

    logic [WORD_W-1:0]   mem [DEPTH];
    logic [WORD_W-1:0]   rd_data_reg;

    logic [PTR_W-1:0]    front_ptr_reg, front_ptr_next;
    logic [PTR_W-1:0]    rear_ptr_reg,  rear_ptr_next;
    logic [PTR_W-1:0]    disp_ptr_reg,  disp_ptr_next;
    logic                is_empty_reg,  is_empty_next;
    logic                mode_reg;
    logic [STATUS_W-1:0] status_reg,    status_next;
    logic                valid_reg,     valid_next;
    logic                last_reg,      last_next;

    logic                allowed;
    logic                full;
    logic                rd_en;
    logic [PTR_W-1:0]    rd_addr;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;

    always_comb
    begin
        unique case (kind)
            KIND_INS_REAR, KIND_REM_FRONT, KIND_DISPLAY: allowed = 1'b1;
            KIND_INS_FRONT: allowed = (mode_reg == MODE_OUTPUT_RESTRICTED);
            KIND_REM_REAR:  allowed = (mode_reg == MODE_INPUT_RESTRICTED);
            default:        allowed = 1'b0;
        endcase
    end

    assign full = !is_empty_reg && (ptr_inc(rear_ptr_reg) == front_ptr_reg);

    always_comb
    begin
        front_ptr_next = front_ptr_reg;
        rear_ptr_next  = rear_ptr_reg;
        disp_ptr_next  = disp_ptr_reg;
        is_empty_next  = is_empty_reg;
        status_next    = status_reg;
        valid_next     = valid_reg;
        last_next      = last_reg;
        rd_en          = 1'b0;
        rd_addr        = front_ptr_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;

        if (cmd.accept)
        begin
            status_next = ST_NOT_ALLOWED;
            valid_next  = 1'b0;
            last_next   = 1'b1;
            if (allowed)
            begin
                case (kind)
                    KIND_INS_REAR, KIND_INS_FRONT:
                    begin
                        if (full)
                        begin
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            wr_en       = 1'b1;
                            if (is_empty_reg)
                            begin
                                front_ptr_next = '0;
                                rear_ptr_next  = '0;
                                is_empty_next  = 1'b0;
                                wr_addr        = '0;
                            end
                            else if (kind == KIND_INS_REAR)
                            begin
                                rear_ptr_next = ptr_inc(rear_ptr_reg);
                                wr_addr       = ptr_inc(rear_ptr_reg);
                            end
                            else
                            begin
                                front_ptr_next = ptr_dec(front_ptr_reg);
                                wr_addr        = ptr_dec(front_ptr_reg);
                            end
                        end
                    end
                    KIND_REM_FRONT, KIND_REM_REAR:
                    begin
                        if (is_empty_reg)
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            valid_next  = 1'b1;
                            rd_en       = 1'b1;
                            rd_addr     = (kind == KIND_REM_REAR) ? rear_ptr_reg
                                                                  : front_ptr_reg;
                            if (front_ptr_reg == rear_ptr_reg)
                            begin
                                is_empty_next  = 1'b1;
                                front_ptr_next = '0;
                                rear_ptr_next  = '0;
                            end
                            else if (kind == KIND_REM_REAR)
                            begin
                                rear_ptr_next = ptr_dec(rear_ptr_reg);
                            end
                            else
                            begin
                                front_ptr_next = ptr_inc(front_ptr_reg);
                            end
                        end
                    end
                    default:
                    begin
                        // display
                        if (is_empty_reg)
                        begin
                            status_next = ST_EMPTY_SHOW;
                        end
                        else
                        begin
                            status_next   = ST_OK;
                            valid_next    = 1'b1;
                            rd_en         = 1'b1;
                            rd_addr       = front_ptr_reg;
                            disp_ptr_next = front_ptr_reg;
                            last_next     = (front_ptr_reg == rear_ptr_reg);
                        end
                    end
                endcase
            end
        end
        else if (cmd.advance)
        begin
            rd_en         = 1'b1;
            rd_addr       = ptr_inc(disp_ptr_reg);
            disp_ptr_next = ptr_inc(disp_ptr_reg);
            last_next     = (ptr_inc(disp_ptr_reg) == rear_ptr_reg);
        end
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= push_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_ptr_reg <= '0;
            rear_ptr_reg  <= '0;
            disp_ptr_reg  <= '0;
            is_empty_reg  <= 1'b1;
            mode_reg      <= MODE_INPUT_RESTRICTED;
            status_reg    <= ST_OK;
            valid_reg     <= 1'b0;
            last_reg      <= 1'b1;
        end
        else
        begin
            front_ptr_reg <= front_ptr_next;
            rear_ptr_reg  <= rear_ptr_next;
            disp_ptr_reg  <= disp_ptr_next;
            is_empty_reg  <= is_empty_next;
            status_reg    <= status_next;
            valid_reg     <= valid_next;
            last_reg      <= last_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    assign sts.last    = last_reg;
    assign status      = status_reg;
    assign value_valid = valid_reg;
    assign out_value   = valid_reg ? signed'(rd_data_reg) : '0;
    assign last        = last_reg;

endmodule

// ===== src/restricted_circular_deque.sv =====
// ----------------------------------------------------------------------------
// restricted_circular_deque
// circular double-ended queue of DEPTH signed words with an input- or
// output-restricted operating mode
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries kind and push_value; output
//   channel (out_valid / out_stall) carries status, value_valid, out_value
//   and last. a transaction moves on a rising edge with valid high, stall low.
//   cfg_wr_en / cfg_wr_data set the mode: 0 input-restricted, 1 output-
//   restricted; write it only while the block is idle.
//   the first result is presented in the cycle after the input transaction.
//   insert, remove and errors give one result. display gives one result
//   per stored word, one per cycle while the receiver does not stall, read
//   in turn from the single-port slot memory. in_stall stays high until
//   the result marked last is taken. a receiver stall holds the current result
//   and freezes the display walk.
//   reset: queue empty, pointers at slot 0, mode input-restricted, no
//   clearing pass; slot contents are undefined until written.
// ----------------------------------------------------------------------------
module restricted_circular_deque
#(
    parameter int DEPTH = rcd_pkg::DEPTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rcd_pkg::KIND_W-1:0]        kind,
    input  logic signed [rcd_pkg::WORD_W-1:0] push_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rcd_pkg::STATUS_W-1:0]      status,
    output logic                              value_valid,
    output logic signed [rcd_pkg::WORD_W-1:0] out_value,
    output logic                              last
);
    import rcd_pkg::*;

    rcd_cmd_t cmd;
    rcd_sts_t sts;

    rcd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rcd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .kind        (kind),
        .push_value  (push_value),
        .cmd         (cmd),
        .sts         (sts),
        .status      (status),
        .value_valid (value_valid),
        .out_value   (out_value),
        .last        (last)
    );

endmodule

// ===== src/rcd_checker.sv =====
// ----------------------------------------------------------------------------
// rcd_checker
// port-level checks on transaction ordering and result coding, bound to
// the top level
// ----------------------------------------------------------------------------
module rcd_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [rcd_pkg::STATUS_W-1:0]      status,
    input logic                              value_valid,
    input logic signed [rcd_pkg::WORD_W-1:0] out_value,
    input logic                              last
);
    import rcd_pkg::*;

    // an accepted input is answered in the next cycle
    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("no result after input transaction");

    // no new input while results are pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while results pending");

    // a display keeps going until the final word
    a_display_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("result sequence cut short");

    // errors are single results with no word
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (last && !value_valid))
        else $error("error result not final or carries a word");

    // no word means a zero value
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !value_valid) |-> (out_value == '0))
        else $error("value present without value_valid");

endmodule

bind restricted_circular_deque rcd_checker u_rcd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .value_valid (value_valid),
    .out_value   (out_value),
    .last        (last)
);

// ===== tb/sv/tb_restricted_circular_deque.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_restricted_circular_deque
// self-checking testbench for the restricted circular deque: a queue-fed
// driver offers operations in random bursts, a built-in deque predictor
// computes the result transactions of every accepted operation, and a
// monitor checks each result against the oldest prediction while the
// receiver stalls on its own pattern, with one long hold-off
// ----------------------------------------------------------------------------
module tb_restricted_circular_deque;

    import rcd_pkg::*;

    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int PTR_W          = $clog2(DEPTH);
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 70;
    localparam int HOLD_AFTER     = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEG_ITEMS      = 20;
    localparam int MAX_REPORTS    = 50;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {PEND_ITEM, PEND_MODE, PEND_DRAIN} pend_tag_t;
    typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_TOGGLE} stall_style_t;

    typedef struct {
        pend_tag_t                tag;
        logic [KIND_W-1:0]        kind;
        logic signed [WORD_W-1:0] value;
        logic                     mode;
    } pend_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     value_valid;
        logic signed [WORD_W-1:0] value;
        logic                     last;
    } deque_result_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic                     cfg_wr_data = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic [KIND_W-1:0]        kind        = '0;
    logic signed [WORD_W-1:0] push_value  = '0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic [STATUS_W-1:0]      status;
    logic                     value_valid;
    logic signed [WORD_W-1:0] out_value;
    logic                     last;

    pend_t         op_queue[$];
    deque_result_t awaited_results[$];

    logic signed [WORD_W-1:0] model_slots [DEPTH];
    logic [PTR_W-1:0]         model_front = '0;
    logic [PTR_W-1:0]         model_rear  = '0;
    logic                     model_empty = 1'b1;
    logic                     model_mode  = MODE_INPUT_RESTRICTED;

    int fail_count   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int mode_writes  = 0;
    int n_overflow   = 0;
    int n_underflow  = 0;
    int n_refused    = 0;
    int n_display    = 0;
    int n_full_show  = 0;

    int burst_left  = 0;
    int gap_left    = 0;
    int settle      = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int phase_left  = 0;
    int idle_cycles = 0;
    stall_style_t stall_style = STALL_NONE;

    restricted_circular_deque #(.DEPTH(DEPTH)) uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .push_value  (push_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .value_valid (value_valid),
        .out_value   (out_value),
        .last        (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

    task automatic push_result(input logic [STATUS_W-1:0] st, input logic vv,
                               input logic signed [WORD_W-1:0] val, input logic fin);
        deque_result_t r;
        r.status      = st;
        r.value_valid = vv;
        r.value       = val;
        r.last        = fin;
        awaited_results.push_back(r);
    endtask

    task automatic apply_deque_op(input logic [KIND_W-1:0] k,
                                  input logic signed [WORD_W-1:0] w);
        logic             allowed;
        logic             fin;
        logic [PTR_W-1:0] p;
        int               n;
        allowed = (k == KIND_INS_REAR) || (k == KIND_REM_FRONT) || (k == KIND_DISPLAY)
               || (k == KIND_INS_FRONT && model_mode == MODE_OUTPUT_RESTRICTED)
               || (k == KIND_REM_REAR && model_mode == MODE_INPUT_RESTRICTED);
        if (!allowed)
        begin
            push_result(ST_NOT_ALLOWED, 1'b0, '0, 1'b1);
            n_refused++;
        end
        else if (k == KIND_INS_REAR || k == KIND_INS_FRONT)
        begin
            if (!model_empty && ptr_inc(model_rear) == model_front)
            begin
                push_result(ST_OVERFLOW, 1'b0, '0, 1'b1);
                n_overflow++;
            end
            else
            begin
                if (model_empty)
                begin
                    model_front    = '0;
                    model_rear     = '0;
                    model_empty    = 1'b0;
                    model_slots[0] = w;
                end
                else if (k == KIND_INS_REAR)
                begin
                    model_rear              = ptr_inc(model_rear);
                    model_slots[model_rear] = w;
                end
                else
                begin
                    model_front              = ptr_dec(model_front);
                    model_slots[model_front] = w;
                end
                push_result(ST_OK, 1'b0, '0, 1'b1);
            end
        end
        else if (k == KIND_REM_FRONT || k == KIND_REM_REAR)
        begin
            if (model_empty)
            begin
                push_result(ST_UNDERFLOW, 1'b0, '0, 1'b1);
                n_underflow++;
            end
            else
            begin
                p = (k == KIND_REM_FRONT) ? model_front : model_rear;
                push_result(ST_OK, 1'b1, model_slots[p], 1'b1);
                if (model_front == model_rear)
                begin
                    model_empty = 1'b1;
                    model_front = '0;
                    model_rear  = '0;
                end
                else if (k == KIND_REM_FRONT)
                    model_front = ptr_inc(model_front);
                else
                    model_rear = ptr_dec(model_rear);
            end
        end
        else
        begin
            n_display++;
            if (model_empty)
                push_result(ST_EMPTY_SHOW, 1'b0, '0, 1'b1);
            else
            begin
                p   = model_front;
                fin = 1'b0;
                n   = 0;
                while (!fin)
                begin
                    fin = (p == model_rear) || (n == DEPTH - 1);
                    push_result(ST_OK, 1'b1, model_slots[p], fin);
                    p = ptr_inc(p);
                    n++;
                end
                if (n == DEPTH)
                    n_full_show++;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch @%0t: %s", $realtime, what);
    endtask

    task automatic add_item(input logic [KIND_W-1:0] k, input logic signed [WORD_W-1:0] w);
        pend_t e;
        e.tag   = PEND_ITEM;
        e.kind  = k;
        e.value = w;
        e.mode  = 1'b0;
        op_queue.push_back(e);
    endtask

    task automatic add_marker(input pend_tag_t tag, input logic m);
        pend_t e;
        e.tag   = tag;
        e.kind  = '0;
        e.value = '0;
        e.mode  = m;
        op_queue.push_back(e);
    endtask

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 11))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input logic m, input int ins_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return KIND_W'($urandom_range(0, 2**KIND_W - 1));
        if (r < 15)
            return KIND_DISPLAY;
        if (r < 15 + ins_pct * 85 / 100)
            return (m == MODE_OUTPUT_RESTRICTED && $urandom_range(0, 1))
                   ? KIND_INS_FRONT : KIND_INS_REAR;
        return (m == MODE_INPUT_RESTRICTED && $urandom_range(0, 1))
               ? KIND_REM_REAR : KIND_REM_FRONT;
    endfunction

    // driver: bursts of operations with random gaps, mode writes only when idle
    always @(posedge clk)
    begin : driver
        logic                     v_nxt;
        logic [KIND_W-1:0]        k_nxt;
        logic signed [WORD_W-1:0] w_nxt;
        logic                     we_nxt;
        logic                     wd_nxt;
        if (rst_n)
        begin
            v_nxt  = in_valid;
            k_nxt  = kind;
            w_nxt  = push_value;
            we_nxt = 1'b0;
            wd_nxt = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                apply_deque_op(kind, push_value);
                void'(op_queue.pop_front());
                items_sent++;
                v_nxt = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (!v_nxt && op_queue.size() > 0)
            begin
                if (op_queue[0].tag != PEND_ITEM)
                begin
                    settle = (awaited_results.size() == 0) ? settle + 1 : 0;
                    if (settle >= SETTLE_CYCLES)
                    begin
                        if (op_queue[0].tag == PEND_MODE)
                        begin
                            we_nxt     = 1'b1;
                            wd_nxt     = op_queue[0].mode;
                            model_mode = op_queue[0].mode;
                            mode_writes++;
                        end
                        void'(op_queue.pop_front());
                        settle = 0;
                    end
                end
                else if (gap_left > 0)
                    gap_left--;
                else
                begin
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 16);
                    v_nxt = 1'b1;
                    k_nxt = op_queue[0].kind;
                    w_nxt = op_queue[0].value;
                end
            end
            in_valid    <= v_nxt;
            kind        <= k_nxt;
            push_value  <= w_nxt;
            cfg_wr_en   <= we_nxt;
            cfg_wr_data <= wd_nxt;
        end
    end

    // receiver stall pattern with one long hold-off
    always @(posedge clk)
    begin : receiver
        logic nxt;
        nxt = 1'b0;
        if (hold_left > 0)
        begin
            hold_left--;
            nxt = 1'b1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            nxt       = 1'b1;
        end
        else
        begin
            if (phase_left == 0)
            begin
                phase_left  = $urandom_range(4, 40);
                stall_style = stall_style_t'($urandom_range(0, 3));
            end
            phase_left--;
            case (stall_style)
                STALL_NONE:   nxt = 1'b0;
                STALL_HALF:   nxt = 1'($urandom_range(0, 1));
                STALL_LIGHT:  nxt = ($urandom_range(0, 3) == 0);
                STALL_TOGGLE: nxt = ~out_stall;
            endcase
        end
        out_stall <= nxt;
    end

    always @(posedge clk)
    begin : monitor
        deque_result_t got;
        deque_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, value_valid, out_value, last};
            results_seen++;
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("unexpected result status=%0d vv=%0b val=%0d last=%0b",
                                          status, value_valid, out_value, last));
            else
            begin
                want = awaited_results.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "got st=%0d vv=%0b val=%0d last=%0b, want st=%0d vv=%0b val=%0d last=%0b",
                        got.status, got.value_valid, got.value, got.last,
                        want.status, want.value_valid, want.value, want.last));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d cycles without a transaction", idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int   seg;
        int   i;
        logic m;
        // input-restricted, empty queue corner cases
        add_item(KIND_DISPLAY,   rand_word());
        add_item(KIND_REM_FRONT, rand_word());
        add_item(KIND_REM_REAR,  rand_word());
        add_item(KIND_INS_FRONT, WORD_MAX);
        add_item(KIND_SPARE_LO,  rand_word());
        add_item(KIND_SPARE_HI,  rand_word());
        add_item(KIND_INS_REAR,  WORD_MAX);
        add_item(KIND_INS_REAR,  WORD_MIN);
        add_item(KIND_INS_REAR,  '0);
        add_item(KIND_INS_REAR,  '1);
        add_item(KIND_DISPLAY,   '0);
        add_item(KIND_REM_REAR,  '0);
        add_item(KIND_REM_FRONT, '0);
        add_item(KIND_REM_FRONT, '0);
        add_item(KIND_REM_REAR,  '0);
        add_item(KIND_DISPLAY,   '0);
        // output-restricted: fill with wrap on the front, overflow, full display
        add_marker(PEND_MODE, MODE_OUTPUT_RESTRICTED);
        for (i = 0; i < DEPTH / 2; i++)
        begin
            add_item(KIND_INS_FRONT, rand_word());
            add_item(KIND_INS_REAR,  rand_word());
        end
        add_item(KIND_INS_FRONT, WORD_MIN);
        add_item(KIND_INS_REAR,  WORD_MAX);
        add_item(KIND_REM_REAR,  '0);
        add_item(KIND_DISPLAY,   '0);
        add_marker(PEND_DRAIN, 1'b0);
        for (seg = 0; seg < 4; seg++)
        begin
            m = seg[0] ? MODE_OUTPUT_RESTRICTED : MODE_INPUT_RESTRICTED;
            add_marker(PEND_MODE, m);
            for (i = 0; i < SEG_ITEMS; i++)
            begin
                if (i == SEG_ITEMS / 2 && seg[0])
                    add_marker(PEND_DRAIN, 1'b0);
                add_item(pick_kind(m, (i < SEG_ITEMS / 2) ? 70 : 30), rand_word());
            end
        end
        while (op_queue.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
        $display("covered %0d operations, %0d results, %0d mode writes, %0d displays (%0d full)",
                 items_sent, results_seen, mode_writes, n_display, n_full_show);
        $display("errors hit: %0d overflow, %0d underflow, %0d refused kinds",
                 n_overflow, n_underflow, n_refused);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
